// ===== sv/hdrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hdrp_pkg
// shared types, tags and tables for the hdr10+ metadata parser
// ----------------------------------------------------------------------------
package hdrp_pkg;

    localparam int MAX_PAYLOAD_BYTES_DEF = 1024;
    localparam int GRID_MAX     = 25;
    localparam int MAXSCL_COUNT = 3;
    localparam logic [5:0] STEP_DONE = 6'd36;

    localparam logic [5:0] TAG_STATUS     = 6'd0;
    localparam logic [5:0] TAG_VERSION    = 6'd1;
    localparam logic [5:0] TAG_NUM_WIN    = 6'd2;
    localparam logic [5:0] TAG_ULX        = 6'd3;
    localparam logic [5:0] TAG_OVERLAP    = 6'd13;
    localparam logic [5:0] TAG_TGT_LUM    = 6'd14;
    localparam logic [5:0] TAG_TGT_FLAG   = 6'd15;
    localparam logic [5:0] TAG_TGT_ROWS   = 6'd16;
    localparam logic [5:0] TAG_TGT_COLS   = 6'd17;
    localparam logic [5:0] TAG_TGT_CELL   = 6'd18;
    localparam logic [5:0] TAG_MAXSCL     = 6'd19;
    localparam logic [5:0] TAG_AVG_RGB    = 6'd20;
    localparam logic [5:0] TAG_PCT_CNT    = 6'd21;
    localparam logic [5:0] TAG_PCTAGE     = 6'd22;
    localparam logic [5:0] TAG_PCTILE     = 6'd23;
    localparam logic [5:0] TAG_BRIGHT     = 6'd24;
    localparam logic [5:0] TAG_MST_FLAG   = 6'd25;
    localparam logic [5:0] TAG_MST_ROWS   = 6'd26;
    localparam logic [5:0] TAG_MST_COLS   = 6'd27;
    localparam logic [5:0] TAG_MST_CELL   = 6'd28;
    localparam logic [5:0] TAG_TM_FLAG    = 6'd29;
    localparam logic [5:0] TAG_KNEE_X     = 6'd30;
    localparam logic [5:0] TAG_ANC_CNT    = 6'd32;
    localparam logic [5:0] TAG_ANCHOR     = 6'd33;
    localparam logic [5:0] TAG_SAT_FLAG   = 6'd34;
    localparam logic [5:0] TAG_SAT_WEIGHT = 6'd35;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_BAD_WIN   = 3'd2;
    localparam logic [2:0] ST_BAD_GRID  = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    localparam logic [10:0] LIMIT_RESET = 11'd907;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  field_tag;
        logic [1:0]  window_index;
        logic [4:0]  first_index;
        logic [4:0]  second_index;
        logic [26:0] field_value;
        logic [2:0]  status;
        logic        last_result;
    } out_item_t;

    // queued byte, with the length check already settled by the front end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       too_long;
    } job_t;

    function automatic logic [4:0] field_width(input logic [5:0] step);
        logic [4:0] w;
        unique case (step)
            6'd1, 6'd9:                                  w = 5'd8;
            6'd2:                                        w = 5'd2;
            6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8,
            6'd10, 6'd11, 6'd12:                         w = 5'd16;
            6'd13, 6'd15, 6'd25, 6'd29, 6'd34:           w = 5'd1;
            6'd14:                                       w = 5'd27;
            6'd16, 6'd17, 6'd26, 6'd27:                  w = 5'd5;
            6'd18, 6'd21, 6'd28, 6'd32:                  w = 5'd4;
            6'd19, 6'd20, 6'd23:                         w = 5'd17;
            6'd22:                                       w = 5'd7;
            6'd24, 6'd33:                                w = 5'd10;
            6'd30, 6'd31:                                w = 5'd12;
            6'd35:                                       w = 5'd6;
            default:                                     w = 5'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/hdrp_stream_if.sv =====
// ----------------------------------------------------------------------------
// hdrp_stream_if
// valid/ready channel carrying one payload of type T
// ----------------------------------------------------------------------------
interface hdrp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/hdrp_front.sv =====
// ----------------------------------------------------------------------------
// hdrp_front
// byte intake: counts payload length, flags oversize, feeds the job queue
// ----------------------------------------------------------------------------
module hdrp_front #(
    parameter int MAX_PAYLOAD_BYTES = hdrp_pkg::MAX_PAYLOAD_BYTES_DEF,
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [10:0]          limit,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hdrp_pkg::in_item_t   in_item,
    output logic                 job_valid,
    input  logic                 job_ready,
    output hdrp_pkg::job_t       job
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [11:0] MAXP = 12'(MAX_PAYLOAD_BYTES);

    hdrp_pkg::job_t   q_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic [10:0]      bytes_reg, bytes_next;
    logic [11:0]      eff_limit;
    logic             push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign job_valid = (cnt_reg != '0);
    assign job       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    assign bytes_next = (bytes_reg == 11'd2047) ? bytes_reg : bytes_reg + 11'd1;
    assign eff_limit  = ({1'b0, limit} < MAXP) ? {1'b0, limit} : MAXP;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg].data_byte <= in_item.data_byte;
            q_reg[wp_reg].last_byte <= in_item.last_byte;
            q_reg[wp_reg].too_long  <= ({1'b0, bytes_next} > eff_limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
            bytes_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg    <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
                bytes_reg <= in_item.last_byte ? 11'd0 : bytes_next;
            end
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("job queue overfilled");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> !push)
        else $error("push into full queue");
    a_count_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (push && in_item.last_byte) |=> bytes_reg == 11'd0)
        else $error("byte count not rearmed");
`endif
endmodule

// ===== sv/hdrp_back.sv =====
// ----------------------------------------------------------------------------
// hdrp_back
// bit-serial syntax walker: one bit per cycle while the output is not stalled, and at payload end the status item
// ----------------------------------------------------------------------------
module hdrp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  hdrp_pkg::job_t     job,
    output logic               out_valid,
    input  logic               out_ready,
    output hdrp_pkg::out_item_t out_item
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BITS = 2'd1;
    localparam logic [1:0] S_STAT = 2'd2;

    logic [1:0]  state_reg;
    logic [7:0]  byte_reg;
    logic        last_reg, long_reg;
    logic [2:0]  bit_reg;
    logic [5:0]  step_reg, step_next;
    logic [26:0] acc_reg, acc_sh;
    logic [4:0]  nb_reg, nb_inc;
    logic [1:0]  wcnt_reg, wcnt_next, wc_reg, wc_next;
    logic [4:0]  rows_reg, rows_next, cols_reg, cols_next;
    logic [4:0]  rc_reg, rc_next, cc_reg, cc_next;
    logic [3:0]  el_reg, el_next, ec_reg, ec_next;
    logic [2:0]  err_reg, err_next;
    logic        ovalid_reg;
    hdrp_pkg::out_item_t o_reg;

    logic        active, done_field, emit_free, group_end, emit;
    logic [26:0] v;
    logic [1:0]  win;
    logic [4:0]  fi, si;
    logic [4:0]  cc_inc, rc_inc;
    logic        gbad;
    logic [2:0]  stat;

    assign out_valid = ovalid_reg;
    assign out_item  = o_reg;
    assign emit_free = !ovalid_reg || out_ready;
    assign job_ready = (state_reg == S_IDLE);

    assign active = (err_reg == 3'd0) && (step_reg != 6'd0) &&
                    (step_reg < hdrp_pkg::STEP_DONE);
    assign acc_sh = {acc_reg[25:0], byte_reg[bit_reg]};
    assign nb_inc = nb_reg + 5'd1;
    assign done_field = active && (nb_inc >= hdrp_pkg::field_width(step_reg));
    assign v = acc_sh;
    assign cc_inc = cc_reg + 5'd1;
    assign rc_inc = rc_reg + 5'd1;
    assign emit = ((state_reg == S_BITS) && done_field && emit_free) ||
                  ((state_reg == S_STAT) && emit_free);

    always_comb
    begin
        win = 2'd0;
        fi  = 5'd0;
        si  = 5'd0;
        if ((step_reg >= 6'd3 && step_reg <= 6'd13) ||
            (step_reg >= 6'd19 && step_reg <= 6'd24) || step_reg >= 6'd29)
            win = wc_reg;
        if (step_reg == hdrp_pkg::TAG_TGT_CELL || step_reg == hdrp_pkg::TAG_MST_CELL)
        begin
            fi = rc_reg;
            si = cc_reg;
        end
        if (step_reg == hdrp_pkg::TAG_MAXSCL || step_reg == hdrp_pkg::TAG_PCTAGE ||
            step_reg == hdrp_pkg::TAG_PCTILE || step_reg == hdrp_pkg::TAG_ANCHOR)
            fi = {1'b0, ec_reg};
    end

    // next syntax element once a field completes
    always_comb
    begin
        step_next = step_reg;
        wcnt_next = wcnt_reg;
        wc_next   = wc_reg;
        rows_next = rows_reg;
        cols_next = cols_reg;
        rc_next   = rc_reg;
        cc_next   = cc_reg;
        el_next   = el_reg;
        ec_next   = ec_reg;
        err_next  = err_reg;
        group_end = 1'b0;
        gbad      = 1'b0;
        case (step_reg)
            hdrp_pkg::TAG_NUM_WIN:
            begin
                wcnt_next = v[1:0];
                if (v[1:0] == 2'd0)
                    err_next = hdrp_pkg::ST_BAD_WIN;
                else if (v[1:0] > 2'd1)
                begin
                    wc_next   = 2'd1;
                    step_next = hdrp_pkg::TAG_ULX;
                end
                else
                    step_next = hdrp_pkg::TAG_TGT_LUM;
            end
            hdrp_pkg::TAG_OVERLAP:
            begin
                wc_next   = wc_reg + 2'd1;
                step_next = ((wc_reg + 2'd1) < wcnt_reg) ? hdrp_pkg::TAG_ULX
                                                        : hdrp_pkg::TAG_TGT_LUM;
            end
            hdrp_pkg::TAG_TGT_FLAG, hdrp_pkg::TAG_MST_FLAG, hdrp_pkg::TAG_SAT_FLAG:
            begin
                if (v[0])
                    step_next = step_reg + 6'd1;
                else
                    group_end = 1'b1;
            end
            hdrp_pkg::TAG_TGT_ROWS, hdrp_pkg::TAG_MST_ROWS:
            begin
                rows_next = v[4:0];
                step_next = step_reg + 6'd1;
            end
            hdrp_pkg::TAG_TGT_COLS, hdrp_pkg::TAG_MST_COLS:
            begin
                cols_next = v[4:0];
                gbad = (rows_reg < 5'd2) || (rows_reg > 5'(hdrp_pkg::GRID_MAX)) ||
                       (v[4:0] < 5'd2) || (v[4:0] > 5'(hdrp_pkg::GRID_MAX));
                if (gbad)
                    err_next = hdrp_pkg::ST_BAD_GRID;
                else
                begin
                    rc_next   = 5'd0;
                    cc_next   = 5'd0;
                    step_next = step_reg + 6'd1;
                end
            end
            hdrp_pkg::TAG_TGT_CELL, hdrp_pkg::TAG_MST_CELL:
            begin
                if (cc_inc >= cols_reg)
                begin
                    cc_next = 5'd0;
                    rc_next = rc_inc;
                    group_end = !(rc_inc < rows_reg);
                end
                else
                    cc_next = cc_inc;
            end
            hdrp_pkg::TAG_MAXSCL:
            begin
                if ((ec_reg + 4'd1) >= 4'(hdrp_pkg::MAXSCL_COUNT))
                begin
                    ec_next   = 4'd0;
                    step_next = hdrp_pkg::TAG_AVG_RGB;
                end
                else
                    ec_next = ec_reg + 4'd1;
            end
            hdrp_pkg::TAG_PCT_CNT, hdrp_pkg::TAG_ANC_CNT:
            begin
                el_next = v[3:0];
                ec_next = 4'd0;
                if (v[3:0] != 4'd0)
                    step_next = step_reg + 6'd1;
                else
                    step_next = (step_reg == hdrp_pkg::TAG_PCT_CNT) ?
                                hdrp_pkg::TAG_BRIGHT : hdrp_pkg::TAG_SAT_FLAG;
            end
            hdrp_pkg::TAG_PCTILE:
            begin
                ec_next   = ec_reg + 4'd1;
                step_next = ((ec_reg + 4'd1) >= el_reg) ? hdrp_pkg::TAG_BRIGHT
                                                       : hdrp_pkg::TAG_PCTAGE;
            end
            hdrp_pkg::TAG_BRIGHT:
            begin
                wc_next   = wc_reg + 2'd1;
                ec_next   = 4'd0;
                step_next = ((wc_reg + 2'd1) < wcnt_reg) ? hdrp_pkg::TAG_MAXSCL
                                                        : hdrp_pkg::TAG_MST_FLAG;
            end
            hdrp_pkg::TAG_TM_FLAG:
                step_next = v[0] ? hdrp_pkg::TAG_KNEE_X : hdrp_pkg::TAG_SAT_FLAG;
            hdrp_pkg::TAG_ANCHOR:
            begin
                ec_next = ec_reg + 4'd1;
                if ((ec_reg + 4'd1) >= el_reg)
                    step_next = hdrp_pkg::TAG_SAT_FLAG;
            end
            hdrp_pkg::TAG_SAT_WEIGHT:
                group_end = 1'b1;
            default:
                step_next = step_reg + 6'd1;
        endcase
        if (group_end)
        begin
            if (step_reg == hdrp_pkg::TAG_TGT_FLAG || step_reg == hdrp_pkg::TAG_TGT_CELL)
            begin
                wc_next   = 2'd0;
                ec_next   = 4'd0;
                step_next = hdrp_pkg::TAG_MAXSCL;
            end
            else if (step_reg == hdrp_pkg::TAG_MST_FLAG ||
                     step_reg == hdrp_pkg::TAG_MST_CELL)
            begin
                wc_next   = 2'd0;
                step_next = hdrp_pkg::TAG_TM_FLAG;
            end
            else
            begin
                wc_next   = wc_reg + 2'd1;
                step_next = ((wc_reg + 2'd1) < wcnt_reg) ? hdrp_pkg::TAG_TM_FLAG
                                                        : hdrp_pkg::STEP_DONE;
            end
        end
    end

    always_comb
    begin
        if (long_reg)
            stat = hdrp_pkg::ST_TOO_LONG;
        else if (err_reg != 3'd0)
            stat = err_reg;
        else if (step_reg != hdrp_pkg::STEP_DONE)
            stat = hdrp_pkg::ST_TRUNCATED;
        else
            stat = hdrp_pkg::ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && job_valid)
        begin
            byte_reg <= job.data_byte;
            last_reg <= job.last_byte;
            long_reg <= job.too_long;
        end
        if (state_reg == S_BITS && done_field && emit_free)
        begin
            o_reg.field_tag    <= step_reg;
            o_reg.window_index <= win;
            o_reg.first_index  <= fi;
            o_reg.second_index <= si;
            o_reg.field_value  <= v;
            o_reg.status       <= hdrp_pkg::ST_OK;
            // last field of a byte that is not the payload end
            o_reg.last_result  <= !last_reg && ((bit_reg == 3'd0) ||
                                  (step_next >= hdrp_pkg::STEP_DONE) ||
                                  (err_next != 3'd0) ||
                                  (hdrp_pkg::field_width(step_next) > {2'b00, bit_reg}));
        end
        else if (state_reg == S_STAT && emit_free)
        begin
            o_reg.field_tag    <= hdrp_pkg::TAG_STATUS;
            o_reg.window_index <= 2'd0;
            o_reg.first_index  <= 5'd0;
            o_reg.second_index <= 5'd0;
            o_reg.field_value  <= 27'd0;
            o_reg.status       <= stat;
            o_reg.last_result  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            bit_reg    <= 3'd7;
            ovalid_reg <= 1'b0;
            step_reg   <= hdrp_pkg::TAG_VERSION;
            acc_reg    <= '0;
            nb_reg     <= '0;
            wcnt_reg   <= '0;
            wc_reg     <= '0;
            rows_reg   <= '0;
            cols_reg   <= '0;
            rc_reg     <= '0;
            cc_reg     <= '0;
            el_reg     <= '0;
            ec_reg     <= '0;
            err_reg    <= '0;
        end
        else
        begin
            if (emit)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        state_reg <= S_BITS;
                        bit_reg   <= 3'd7;
                    end
                S_BITS:
                    if (!active)
                        state_reg <= last_reg ? S_STAT : S_IDLE;
                    else if (!done_field || emit_free)
                    begin
                        if (done_field)
                        begin
                            acc_reg  <= '0;
                            nb_reg   <= '0;
                            step_reg <= step_next;
                            wcnt_reg <= wcnt_next;
                            wc_reg   <= wc_next;
                            rows_reg <= rows_next;
                            cols_reg <= cols_next;
                            rc_reg   <= rc_next;
                            cc_reg   <= cc_next;
                            el_reg   <= el_next;
                            ec_reg   <= ec_next;
                            err_reg  <= err_next;
                        end
                        else
                        begin
                            acc_reg <= acc_sh;
                            nb_reg  <= nb_inc;
                        end
                        bit_reg <= bit_reg - 3'd1;
                        if (bit_reg == 3'd0)
                            state_reg <= last_reg ? S_STAT : S_IDLE;
                    end
                S_STAT:
                    if (emit_free)
                    begin
                        state_reg  <= S_IDLE;
                        step_reg   <= hdrp_pkg::TAG_VERSION;
                        acc_reg    <= '0;
                        nb_reg     <= '0;
                        wcnt_reg   <= '0;
                        wc_reg     <= '0;
                        rows_reg   <= '0;
                        cols_reg   <= '0;
                        rc_reg     <= '0;
                        cc_reg     <= '0;
                        el_reg     <= '0;
                        ec_reg     <= '0;
                        err_reg    <= '0;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ready) |=> $stable(o_reg))
        else $error("result changed while stalled");
    a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != 3'd0 && state_reg == S_BITS) |=> $stable(step_reg))
        else $error("parse advanced after error");
    a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && o_reg.field_tag == hdrp_pkg::TAG_STATUS) |-> o_reg.last_result)
        else $error("status item without last flag");
`endif
endmodule

// ===== sv/hdr10plus_metadata_parser_core.sv =====
// ----------------------------------------------------------------------------
// hdr10plus_metadata_parser_core
// hdr10+ dynamic metadata parser, byte stream in, tagged field items out
// ----------------------------------------------------------------------------
// channel   dir   payload                                  moves on
// in_ch     in    data_byte, last_byte                     valid & ready
// out_ch    out   tag, indices, value, status, last_result valid & ready
// cfg       in    payload_limit_bytes (11 bits)            cfg_we
//
// the bit-serial walker takes a byte in, then walks it one bit at a time;
// after parsing stops bytes are only taken in; the last adds a status item.
// a two-entry queue lets bytes be taken while the walker is busy.
// a stalled output holds the walker at the bit that completes a field.
// reset clears the parse state and sets the limit to 907.
// ----------------------------------------------------------------------------
module hdr10plus_metadata_parser_core #(
    parameter int MAX_PAYLOAD_BYTES = hdrp_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    hdrp_stream_if.sink   in_ch,
    hdrp_stream_if.source out_ch,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);
    logic [10:0]    limit_reg;
    logic           job_valid, job_ready;
    hdrp_pkg::job_t job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= hdrp_pkg::LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    hdrp_front #(.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (in_ch.payload),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    hdrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_ch.payload)
    );
endmodule
